FILE: rtl/core/clle_pkg.sv
// ----------------------------------------------------------------------------
// clle_pkg
// types and command codes shared by the linked list engine
// ----------------------------------------------------------------------------
package clle_pkg;

    localparam logic [4:0] CMD_CLEAR      = 5'd0;
    localparam logic [4:0] CMD_INS_FIRST  = 5'd1;
    localparam logic [4:0] CMD_INS_LAST   = 5'd2;
    localparam logic [4:0] CMD_FIRST      = 5'd3;
    localparam logic [4:0] CMD_LAST       = 5'd4;
    localparam logic [4:0] CMD_GET_FIRST  = 5'd5;
    localparam logic [4:0] CMD_GET_LAST   = 5'd6;
    localparam logic [4:0] CMD_DEL_FIRST  = 5'd7;
    localparam logic [4:0] CMD_DEL_LAST   = 5'd8;
    localparam logic [4:0] CMD_DEL_AFTER  = 5'd9;
    localparam logic [4:0] CMD_DEL_BEFORE = 5'd10;
    localparam logic [4:0] CMD_INS_AFTER  = 5'd11;
    localparam logic [4:0] CMD_INS_BEFORE = 5'd12;
    localparam logic [4:0] CMD_GET        = 5'd13;
    localparam logic [4:0] CMD_SET        = 5'd14;
    localparam logic [4:0] CMD_NEXT       = 5'd15;
    localparam logic [4:0] CMD_PREV       = 5'd16;
    localparam logic [4:0] CMD_IS_ACTIVE  = 5'd17;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [31:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               error;
        logic               cursor_valid;
    } t_out_item;

endpackage

FILE: rtl/core/clle_node_mem.sv
// ----------------------------------------------------------------------------
// clle_node_mem
// node pool: value, next and prev link arrays, one port each, registered read
// ----------------------------------------------------------------------------
module clle_node_mem #(
    parameter int NODES = 64,
    parameter int IW    = 7
) (
    input  logic               i_clk,
    input  logic [IW-2:0]      i_addr,
    input  logic               i_we_val,
    input  logic               i_we_nxt,
    input  logic               i_we_prv,
    input  logic signed [31:0] i_val,
    input  logic [IW-1:0]      i_nxt,
    input  logic [IW-1:0]      i_prv,
    output logic signed [31:0] o_val,
    output logic [IW-1:0]      o_nxt,
    output logic [IW-1:0]      o_prv
);

    logic signed [31:0] r_val_mem [NODES];
    logic [IW-1:0]      r_nxt_mem [NODES];
    logic [IW-1:0]      r_prv_mem [NODES];

    always_ff @(posedge i_clk) begin
        if (i_we_val) r_val_mem[i_addr] <= i_val;
        if (i_we_nxt) r_nxt_mem[i_addr] <= i_nxt;
        if (i_we_prv) r_prv_mem[i_addr] <= i_prv;
        o_val <= r_val_mem[i_addr];
        o_nxt <= r_nxt_mem[i_addr];
        o_prv <= r_prv_mem[i_addr];
    end

endmodule

FILE: rtl/core/clle_free_stack.sv
// ----------------------------------------------------------------------------
// clle_free_stack
// stack of recycled node indexes, registered read of the top entry
// ----------------------------------------------------------------------------
module clle_free_stack #(
    parameter int NODES = 64,
    parameter int IW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-2:0] i_addr,
    input  logic [IW-2:0] i_wdata,
    output logic [IW-2:0] o_rdata
);

    logic [IW-2:0] r_mem [NODES];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end

endmodule

FILE: rtl/core/cursor_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core
// doubly linked list with cursor over a node pool, one command per item
// ----------------------------------------------------------------------------
// One command is taken at a time. Clear, set and commands that touch only
// head, tail or cursor go from decode to the output. Gets, next and prev read
// the node memory first. Inserts take a node off the recycle stack or a
// fresh index, write it and fix both neighbours; deletes read the victim's
// links, fix both and push it on the stack. Those beside the cursor read
// the cursor node first. The single-port node memory is read and rewritten
// one entry per cycle. The result waits in an output register. A new item
// is taken once the previous result has left it.
module cursor_linked_list_engine_core #(
    parameter int NODES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  clle_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output clle_pkg::t_out_item  o_out_item
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int IW = AW + 1;
    localparam logic [IW-1:0] NULL_IDX = IW'(NODES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // read issued, wait
    localparam logic [3:0] S_RDV   = 4'd2;  // read data ready
    localparam logic [3:0] S_POP   = 4'd3;  // stack top read issued
    localparam logic [3:0] S_POPV  = 4'd4;
    localparam logic [3:0] S_LINK  = 4'd5;  // write new node
    localparam logic [3:0] S_FIXP  = 4'd6;  // fix neighbor p
    localparam logic [3:0] S_FIXQ  = 4'd7;  // fix neighbor q
    localparam logic [3:0] S_DELR  = 4'd8;  // victim links read issued
    localparam logic [3:0] S_DELV  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]         r_state, n_state;
    logic [4:0]         r_cmd;
    logic signed [31:0] r_data;
    logic [IW-1:0]      r_head, r_tail, r_cur, r_fresh, r_depth;
    logic [IW-1:0]      r_p, r_q, r_n;
    logic               r_err;
    logic signed [31:0] r_rd;
    logic               r_out_valid;
    clle_pkg::t_out_item r_out;

    logic [AW-1:0]      m_addr;
    logic               m_we_val, m_we_nxt, m_we_prv;
    logic signed [31:0] m_wval, m_rval;
    logic [IW-1:0]      m_wnxt, m_wprv, m_rnxt, m_rprv;
    logic               s_we;
    logic [AW-1:0]      s_addr, s_wdata, s_rdata;

    clle_node_mem #(.NODES(NODES), .IW(IW)) u_mem (
        .i_clk(i_clk), .i_addr(m_addr), .i_we_val(m_we_val), .i_we_nxt(m_we_nxt),
        .i_we_prv(m_we_prv), .i_val(m_wval), .i_nxt(m_wnxt), .i_prv(m_wprv),
        .o_val(m_rval), .o_nxt(m_rnxt), .o_prv(m_rprv)
    );

    clle_free_stack #(.NODES(NODES), .IW(IW)) u_stk (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wdata),
        .o_rdata(s_rdata)
    );

    function automatic logic live(input logic [IW-1:0] x);
        return x < NULL_IDX;
    endfunction

    logic accept;
    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    logic is_ins, is_get;
    always_comb begin
        is_ins = (r_cmd == clle_pkg::CMD_INS_FIRST) || (r_cmd == clle_pkg::CMD_INS_LAST)
              || (r_cmd == clle_pkg::CMD_INS_AFTER) || (r_cmd == clle_pkg::CMD_INS_BEFORE);
        is_get = (r_cmd == clle_pkg::CMD_GET_FIRST) || (r_cmd == clle_pkg::CMD_GET_LAST)
              || (r_cmd == clle_pkg::CMD_GET);
    end

    logic [IW-1:0] n_head, n_tail, n_cur, n_fresh, n_depth, n_p, n_q, n_n;
    logic          n_err;
    logic signed [31:0] n_rd;

    always_comb begin
        n_state = r_state;
        n_head = r_head; n_tail = r_tail; n_cur = r_cur;
        n_fresh = r_fresh; n_depth = r_depth;
        n_p = r_p; n_q = r_q; n_n = r_n; n_err = r_err; n_rd = r_rd;
        m_addr = AW'(r_cur); m_we_val = 1'b0; m_we_nxt = 1'b0; m_we_prv = 1'b0;
        m_wval = r_data; m_wnxt = r_q; m_wprv = r_p;
        s_we = 1'b0; s_addr = AW'(r_depth - IW'(1)); s_wdata = AW'(r_n);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RD; n_err = 1'b0; n_rd = '0;
                end
            end
            S_RD: begin
                // decide what to read
                n_state = S_OUT;
                unique case (r_cmd) inside
                    clle_pkg::CMD_CLEAR: begin
                        n_head = NULL_IDX; n_tail = NULL_IDX; n_cur = NULL_IDX;
                        n_fresh = '0; n_depth = '0;
                    end
                    clle_pkg::CMD_FIRST: n_cur = r_head;
                    clle_pkg::CMD_LAST:  n_cur = r_tail;
                    clle_pkg::CMD_GET_FIRST, clle_pkg::CMD_GET_LAST, clle_pkg::CMD_GET: begin
                        n_n = (r_cmd == clle_pkg::CMD_GET_FIRST) ? r_head
                            : (r_cmd == clle_pkg::CMD_GET_LAST) ? r_tail : r_cur;
                        m_addr = AW'(n_n);
                        if (live(n_n)) n_state = S_RDV; else n_err = 1'b1;
                    end
                    clle_pkg::CMD_SET: begin
                        m_we_val = live(r_cur);
                    end
                    clle_pkg::CMD_INS_FIRST: begin
                        n_p = NULL_IDX; n_q = r_head; n_state = S_POP;
                    end
                    clle_pkg::CMD_INS_LAST: begin
                        n_p = r_tail; n_q = NULL_IDX; n_state = S_POP;
                    end
                    clle_pkg::CMD_DEL_FIRST: begin
                        n_n = r_head; if (live(r_head)) n_state = S_DELR;
                    end
                    clle_pkg::CMD_DEL_LAST: begin
                        n_n = r_tail; if (live(r_tail)) n_state = S_DELR;
                    end
                    clle_pkg::CMD_DEL_AFTER, clle_pkg::CMD_DEL_BEFORE,
                    clle_pkg::CMD_INS_AFTER, clle_pkg::CMD_INS_BEFORE,
                    clle_pkg::CMD_NEXT, clle_pkg::CMD_PREV: begin
                        n_n = r_cur;
                        if (live(r_cur)) n_state = S_RDV;
                    end
                    default: ;
                endcase
            end
            S_RDV: begin
                // wait for the registered read, address held
                m_addr = AW'(r_n);
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_OUT;
                unique case (r_cmd) inside
                    clle_pkg::CMD_GET_FIRST, clle_pkg::CMD_GET_LAST, clle_pkg::CMD_GET:
                        n_rd = m_rval;
                    clle_pkg::CMD_NEXT: n_cur = live(m_rnxt) ? m_rnxt : NULL_IDX;
                    clle_pkg::CMD_PREV: n_cur = live(m_rprv) ? m_rprv : NULL_IDX;
                    clle_pkg::CMD_INS_AFTER: begin
                        n_p = r_cur; n_q = m_rnxt; n_state = S_POP;
                    end
                    clle_pkg::CMD_INS_BEFORE: begin
                        n_p = m_rprv; n_q = r_cur; n_state = S_POP;
                    end
                    clle_pkg::CMD_DEL_AFTER: begin
                        n_n = m_rnxt; if (live(m_rnxt)) n_state = S_DELR;
                    end
                    clle_pkg::CMD_DEL_BEFORE: begin
                        n_n = m_rprv; if (live(m_rprv)) n_state = S_DELR;
                    end
                    default: ;
                endcase
            end
            S_POP: begin
                if (r_depth != '0) begin
                    n_depth = r_depth - IW'(1);
                    n_state = S_POPV;
                end else if (r_fresh < NULL_IDX) begin
                    n_n = r_fresh; n_fresh = r_fresh + IW'(1); n_state = S_LINK;
                end else begin
                    n_err = 1'b1; n_state = S_OUT;
                end
            end
            S_POPV: begin
                s_addr = AW'(r_depth);
                n_state = S_LINK;
                n_n = {1'b0, s_rdata};
            end
            S_LINK: begin
                m_addr = AW'(r_n); m_we_val = 1'b1; m_we_nxt = 1'b1; m_we_prv = 1'b1;
                m_wval = r_data; m_wprv = r_p; m_wnxt = r_q;
                n_state = S_FIXP;
                if (!live(r_p)) n_head = r_n;
                if (!live(r_q)) n_tail = r_n;
            end
            S_FIXP: begin
                n_state = S_FIXQ;
                if (is_ins) begin
                    m_addr = AW'(r_p); m_we_nxt = live(r_p); m_wnxt = r_n;
                end else begin
                    m_addr = AW'(r_p); m_we_nxt = live(r_p); m_wnxt = r_q;
                end
            end
            S_FIXQ: begin
                n_state = S_OUT;
                m_addr = AW'(r_q); m_we_prv = live(r_q);
                m_wprv = is_ins ? r_n : r_p;
                if (!is_ins) begin
                    s_we = 1'b1; s_addr = AW'(r_depth); s_wdata = AW'(r_n);
                    n_depth = r_depth + IW'(1);
                end
            end
            S_DELR: begin
                m_addr = AW'(r_n);
                n_state = S_DELV;
            end
            S_DELV: begin
                n_p = m_rprv; n_q = m_rnxt;
                if (live(m_rprv)) n_head = r_head; else n_head = m_rnxt;
                if (live(m_rnxt)) n_tail = r_tail; else n_tail = m_rprv;
                if (r_cur == r_n) n_cur = NULL_IDX;
                n_state = S_FIXP;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_DELR) m_addr = AW'(r_n);
        if (r_state == S_POP) s_addr = AW'(r_depth - IW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= NULL_IDX; r_tail <= NULL_IDX; r_cur <= NULL_IDX;
            r_fresh <= '0; r_depth <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head; r_tail <= n_tail; r_cur <= n_cur;
            r_fresh <= n_fresh; r_depth <= n_depth;
            if (r_state == S_OUT) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in_item.command;
            r_data <= i_in_item.data_value;
        end
        r_p <= n_p; r_q <= n_q; r_n <= n_n; r_err <= n_err;
        r_rd <= is_get ? n_rd : '0;
        if (r_state == S_OUT) begin
            r_out.read_value   <= r_err ? '0 : r_rd;
            r_out.error        <= r_err;
            r_out.cursor_valid <= live(r_cur);
        end
    end

endmodule

FILE: tb/sv/tb_cursor_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// tb_cursor_linked_list_engine_core
// drives list commands through the engine and checks every result against
// a shadow list kept in the testbench, with random bursts and output stalls
// ----------------------------------------------------------------------------
module tb_cursor_linked_list_engine_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 64;
    localparam logic [6:0] NIL = 7'd64;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    clle_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    clle_pkg::t_out_item out_item;

    cursor_linked_list_engine_core #(.NODES(NODES)) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow list
    logic [31:0] sh_value [NODES];
    logic [6:0]  sh_next [NODES];
    logic [6:0]  sh_prev [NODES];
    logic [6:0]  sh_stack [NODES];
    logic [6:0]  sh_head = NIL, sh_tail = NIL, sh_cursor = NIL;
    logic [6:0]  sh_fresh = '0, sh_depth = '0;

    clle_pkg::t_in_item  pending_items [$];
    clle_pkg::t_out_item expected_results [$];
    int          err_count = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    bit          hold_off = 1'b0;
    int          stall_mode = 0;

    function automatic bit is_live(logic [6:0] i);
        return i < NIL;
    endfunction

    function automatic logic [6:0] node_after(logic [6:0] i);
        return is_live(i) ? sh_next[i[5:0]] : NIL;
    endfunction

    function automatic logic [6:0] node_before(logic [6:0] i);
        return is_live(i) ? sh_prev[i[5:0]] : NIL;
    endfunction

    function automatic bit splice_in(logic [6:0] p, logic [6:0] q, logic [31:0] v);
        logic [6:0] n;
        if (sh_depth > 0) begin
            sh_depth = sh_depth - 7'd1;
            n = sh_stack[sh_depth[5:0]];
        end else if (sh_fresh < NIL) begin
            n = sh_fresh;
            sh_fresh = sh_fresh + 7'd1;
        end else begin
            return 1'b1;
        end
        sh_value[n[5:0]] = v;
        sh_prev[n[5:0]] = p;
        sh_next[n[5:0]] = q;
        if (is_live(p)) sh_next[p[5:0]] = n; else sh_head = n;
        if (is_live(q)) sh_prev[q[5:0]] = n; else sh_tail = n;
        return 1'b0;
    endfunction

    function automatic void splice_out(logic [6:0] n);
        logic [6:0] p, q;
        if (!is_live(n)) return;
        p = sh_prev[n[5:0]];
        q = sh_next[n[5:0]];
        if (is_live(p)) sh_next[p[5:0]] = q; else sh_head = q;
        if (is_live(q)) sh_prev[q[5:0]] = p; else sh_tail = p;
        if (sh_cursor == n) sh_cursor = NIL;
        if (sh_depth < NIL) begin
            sh_stack[sh_depth[5:0]] = n;
            sh_depth = sh_depth + 7'd1;
        end
    endfunction

    function automatic clle_pkg::t_out_item apply_command(clle_pkg::t_in_item it);
        clle_pkg::t_out_item r;
        logic [6:0]          c;
        r = '0;
        c = sh_cursor;
        unique case (it.command)
            clle_pkg::CMD_CLEAR: begin
                sh_head = NIL; sh_tail = NIL; sh_cursor = NIL;
                sh_fresh = '0; sh_depth = '0;
            end
            clle_pkg::CMD_INS_FIRST: r.error = splice_in(NIL, sh_head, it.data_value);
            clle_pkg::CMD_INS_LAST:  r.error = splice_in(sh_tail, NIL, it.data_value);
            clle_pkg::CMD_FIRST:     sh_cursor = sh_head;
            clle_pkg::CMD_LAST:      sh_cursor = sh_tail;
            clle_pkg::CMD_GET_FIRST:
                if (is_live(sh_head)) r.read_value = sh_value[sh_head[5:0]];
                else r.error = 1'b1;
            clle_pkg::CMD_GET_LAST:
                if (is_live(sh_tail)) r.read_value = sh_value[sh_tail[5:0]];
                else r.error = 1'b1;
            clle_pkg::CMD_DEL_FIRST:  splice_out(sh_head);
            clle_pkg::CMD_DEL_LAST:   splice_out(sh_tail);
            clle_pkg::CMD_DEL_AFTER:  if (is_live(c)) splice_out(node_after(c));
            clle_pkg::CMD_DEL_BEFORE: if (is_live(c)) splice_out(node_before(c));
            clle_pkg::CMD_INS_AFTER:
                if (is_live(c)) r.error = splice_in(c, node_after(c), it.data_value);
            clle_pkg::CMD_INS_BEFORE:
                if (is_live(c)) r.error = splice_in(node_before(c), c, it.data_value);
            clle_pkg::CMD_GET:
                if (is_live(c)) r.read_value = sh_value[c[5:0]]; else r.error = 1'b1;
            clle_pkg::CMD_SET:  if (is_live(c)) sh_value[c[5:0]] = it.data_value;
            clle_pkg::CMD_NEXT: if (is_live(c)) sh_cursor = node_after(c);
            clle_pkg::CMD_PREV: if (is_live(c)) sh_cursor = node_before(c);
            default: ;
        endcase
        r.cursor_valid = is_live(sh_cursor);
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_cmd(logic [4:0] c, logic [31:0] v);
        clle_pkg::t_in_item it;
        it.command = c;
        it.data_value = v;
        pending_items.push_back(it);
    endtask

    // driver: bursts and gaps; prediction at acceptance
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            expected_results.push_back(apply_command(in_item));
        end
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && in_stall)) begin
            if (in_valid && !in_stall && pending_items.size() > 0 && burst_left > 0
                && !hold_off) begin
                in_item <= pending_items.pop_front();
                burst_left <= burst_left - 1;
            end else if (gap_left > 0 || hold_off || pending_items.size() == 0) begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else if (burst_left == 0) begin
                in_valid <= 1'b0;
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
                in_valid <= 1'b1;
                in_item <= pending_items.pop_front();
                burst_left <= burst_left - 1;
            end
        end
    end

    // monitor and output stall pattern
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected item: read_value %0d", out_item.read_value);
                err_count++;
            end else begin
                clle_pkg::t_out_item e;
                e = expected_results.pop_front();
                if (out_item.read_value !== e.read_value) begin
                    $error("read_value expected %0d actual %0d",
                           e.read_value, out_item.read_value);
                    err_count++;
                end
                if (out_item.error !== e.error) begin
                    $error("error expected %0b actual %0b", e.error, out_item.error);
                    err_count++;
                end
                if (out_item.cursor_valid !== e.cursor_valid) begin
                    $error("cursor_valid expected %0b actual %0b",
                           e.cursor_valid, out_item.cursor_valid);
                    err_count++;
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_cursor_linked_list_engine_core: done, errors");
            $finish;
        end
    end

    initial begin
        int          n, len;
        logic [4:0]  c;
        // directed: empty-list reads and no-ops, then the extremes
        push_cmd(clle_pkg::CMD_GET_FIRST, 0);
        push_cmd(clle_pkg::CMD_GET_LAST, 0);
        push_cmd(clle_pkg::CMD_GET, 0);
        push_cmd(clle_pkg::CMD_DEL_FIRST, 0);
        push_cmd(clle_pkg::CMD_DEL_AFTER, 0);
        push_cmd(clle_pkg::CMD_INS_AFTER, 5);
        push_cmd(clle_pkg::CMD_SET, 9);
        push_cmd(clle_pkg::CMD_NEXT, 0);
        push_cmd(clle_pkg::CMD_INS_FIRST, 32'h8000_0000);
        push_cmd(clle_pkg::CMD_INS_LAST, 32'h7fff_ffff);
        push_cmd(clle_pkg::CMD_FIRST, 0);
        push_cmd(clle_pkg::CMD_INS_AFTER, 32'hffff_ffff);
        push_cmd(clle_pkg::CMD_INS_BEFORE, 32'h5555_aaaa);
        push_cmd(clle_pkg::CMD_GET, 0);
        push_cmd(clle_pkg::CMD_SET, 32'haaaa_5555);
        push_cmd(clle_pkg::CMD_GET_FIRST, 0);
        push_cmd(clle_pkg::CMD_GET_LAST, 0);
        push_cmd(clle_pkg::CMD_DEL_AFTER, 0);
        push_cmd(clle_pkg::CMD_DEL_BEFORE, 0);
        push_cmd(clle_pkg::CMD_PREV, 0);
        push_cmd(clle_pkg::CMD_IS_ACTIVE, 0);
        push_cmd(clle_pkg::CMD_LAST, 0);
        push_cmd(clle_pkg::CMD_DEL_LAST, 0);
        push_cmd(clle_pkg::CMD_IS_ACTIVE, 0);
        // unassigned command code
        push_cmd(5'd31, 32'hdead_beef);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // pool exhaustion: fill, the inserts beyond the pool fail, then drain and reuse
        push_cmd(clle_pkg::CMD_CLEAR, 0);
        for (int i = 0; i < NODES + 2; i++) push_cmd(clle_pkg::CMD_INS_LAST, random_word());
        push_cmd(clle_pkg::CMD_FIRST, 0);
        push_cmd(clle_pkg::CMD_INS_AFTER, 1);
        for (int i = 0; i < 20; i++) push_cmd(clle_pkg::CMD_DEL_FIRST, 0);
        push_cmd(clle_pkg::CMD_INS_FIRST, 32'h1234_5678);
        wait (pending_items.size() == 0);
        // pause until every result has come back
        hold_off = 1'b1;
        wait (expected_results.size() == 0 && !in_valid);
        repeat (10) @(posedge clk);
        hold_off = 1'b0;
        n = 0;
        while (n < 760) begin
            len = $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0) begin
                push_cmd(clle_pkg::CMD_CLEAR, 0);
                n++;
            end
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 9)) inside
                    [0:2]: c = ($urandom_range(0, 2) == 0) ? clle_pkg::CMD_INS_FIRST
                                                          : clle_pkg::CMD_INS_LAST;
                    [3:4]: c = $urandom_range(0, 1) ? clle_pkg::CMD_INS_AFTER
                                                   : clle_pkg::CMD_INS_BEFORE;
                    5: begin
                        // unassigned codes or deletes
                        if ($urandom_range(0, 3) == 0)
                            c = 5'($urandom_range(int'(clle_pkg::CMD_IS_ACTIVE) + 1, 31));
                        else
                            c = 5'($urandom_range(int'(clle_pkg::CMD_DEL_FIRST),
                                                  int'(clle_pkg::CMD_DEL_BEFORE)));
                    end
                    default: c = 5'($urandom_range(int'(clle_pkg::CMD_CLEAR),
                                                   int'(clle_pkg::CMD_IS_ACTIVE)));
                endcase
                push_cmd(c, random_word());
                n++;
            end
            wait (pending_items.size() < 8);
        end
        wait (pending_items.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (err_count == 0 && !out_valid) begin
            $display("tb_cursor_linked_list_engine_core: done, clean");
        end else begin
            $display("tb_cursor_linked_list_engine_core: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/clle_pkg.sv
rtl/core/clle_node_mem.sv
rtl/core/clle_free_stack.sv
rtl/core/cursor_linked_list_engine_core.sv
tb/sv/tb_cursor_linked_list_engine_core.sv
